FILE: rtl/rsp_pkg.sv
package rsp_pkg;

    localparam int POSITION_WIDTH = 16;
    localparam int POS_W          = POSITION_WIDTH + 1;
    localparam int LEN_EFF_W      = (POSITION_WIDTH < 16) ? POSITION_WIDTH : 16;

    localparam logic [7:0] CMD_BURST      = 8'd253;
    localparam logic [7:0] CMD_DELAY      = 8'd254;
    localparam logic [7:0] CLOSE_PAGE_REG = 8'h7F;

    localparam logic [1:0] CFG_SCRIPT_LENGTH = 2'd0;
    localparam logic [1:0] CFG_START_ODD     = 2'd1;
    localparam logic [1:0] CFG_TARGET_AMP    = 2'd2;

    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_BURST  = 2'd1;
    localparam logic [1:0] KIND_DELAY  = 2'd2;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_CMD,
        PH_PARAM,
        PH_BURST,
        PH_PAD
    } t_phase;

    typedef struct packed {
        logic [7:0] script_byte;
        logic       start_of_script;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic       all_amps;
        logic [7:0] reg_addr;
        logic [7:0] value;
        logic       burst_first;
        logic       last;
        logic       script_done;
    } t_out;

endpackage

FILE: rtl/register_script_player_unit.sv
// Register script player.
// Script bytes come in on the input channel (i_in_valid / o_in_stall), one
// byte per request, with start_of_script set on the first byte of a script.
// Each byte yields zero or one parsed result (single write, burst byte or
// delay request); the byte that ends the script adds three closing writes to
// all amplifiers, so one byte gives at most four results. Results leave on
// the output channel (o_out_valid / i_out_stall), one per cycle while the
// receiver does not stall, with last set on the final result of each byte.
// A byte's results are registered in the result slot, then in the output register.
// Throughput: one byte per cycle while the output is not stalled; a byte that
// gives n > 1 results stalls the input until its last result is taken, set
// by the single output register draining its result slot one result per cycle.
// The result slot and the output register are separate, so a new byte is
// taken while a finished result waits on a stalled receiver. A stall holds
// the output register and, once the slot is full, stalls the input.
// Reset (synchronous, active low) clears the configuration to zero, empties
// the slot and output, and parks the parser waiting for a start byte.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data;
// target_amp (index 2) is accepted but does not affect any result.
module register_script_player_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rsp_pkg::t_in        i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rsp_pkg::t_out       o_out_data
);
    import rsp_pkg::*;

    logic [15:0]      r_len;
    logic             r_odd;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_rem, n_rem;
    logic             r_first, n_first;

    // result slot: optional parsed result plus optional closing sequence
    logic             r_ent_valid, n_ent_valid;
    logic             r_ent_prim;
    logic             r_ent_close;
    t_out             r_ent_res;
    logic [1:0]       r_seq, n_seq;

    logic             r_out_valid;
    t_out             r_out;

    logic             p_prim, p_close;
    t_out             p_res;

    t_phase           e_phase;
    logic [POS_W-1:0] e_pos, pos_adv;
    logic [7:0]       e_cmd, e_rem, rem_dec;
    logic             e_first;
    logic [POS_W:0]   len_ext;
    logic             pad_bit, end_plain, end_burst;
    logic [7:0]       b;

    logic             in_acc, out_free, seq_last;
    logic [2:0]       ent_cnt;
    logic [1:0]       close_step;
    t_out             cur_res;

    assign b       = i_in_data.script_byte;
    assign len_ext = (POS_W+1)'(r_len[LEN_EFF_W-1:0]);

    // ---------------- parser ----------------
    always_comb begin
        e_phase = r_phase;
        e_pos   = r_pos;
        e_cmd   = r_cmd;
        e_rem   = r_rem;
        e_first = r_first;
        if (i_in_data.start_of_script) begin
            e_phase = PH_CMD;
            e_pos   = '0;
            e_cmd   = '0;
            e_rem   = '0;
            e_first = 1'b0;
        end
        pos_adv   = (e_pos == {POS_W{1'b1}}) ? e_pos : e_pos + POS_W'(1);
        pad_bit   = r_odd ^ pos_adv[0];
        end_plain = {1'b0, pos_adv} >= len_ext;
        end_burst = ({1'b0, pos_adv} + (POS_W+1)'(pad_bit)) >= len_ext;
        rem_dec   = e_rem - 8'd1;

        n_phase = e_phase;
        n_pos   = e_pos;
        n_cmd   = e_cmd;
        n_rem   = e_rem;
        n_first = e_first;
        p_prim  = 1'b0;
        p_close = 1'b0;
        p_res   = '0;

        if (i_in_data.start_of_script && (len_ext == '0)) begin
            p_close = 1'b1;
            n_phase = PH_DONE;
        end else begin
            unique case (e_phase)
                PH_CMD: begin
                    n_cmd   = b;
                    n_pos   = pos_adv;
                    n_phase = PH_PARAM;
                end
                PH_PARAM: begin
                    n_pos = pos_adv;
                    if (e_cmd == CMD_BURST) begin
                        n_rem   = b;
                        n_first = 1'b1;
                        if (b != 8'd0) begin
                            n_phase = PH_BURST;
                        end else if (end_burst) begin
                            p_close = 1'b1;
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = pad_bit ? PH_PAD : PH_CMD;
                        end
                    end else begin
                        p_prim      = 1'b1;
                        p_res.value = b;
                        if (e_cmd == CMD_DELAY) begin
                            p_res.kind = KIND_DELAY;
                        end else begin
                            p_res.kind     = KIND_SINGLE;
                            p_res.reg_addr = e_cmd;
                        end
                        if (end_plain) begin
                            p_close = 1'b1;
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_CMD;
                        end
                    end
                end
                PH_BURST: begin
                    n_pos             = pos_adv;
                    p_prim            = 1'b1;
                    p_res.kind        = KIND_BURST;
                    p_res.value       = b;
                    p_res.burst_first = e_first;
                    n_first           = 1'b0;
                    n_rem             = rem_dec;
                    if (rem_dec == 8'd0) begin
                        if (end_burst) begin
                            p_close = 1'b1;
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = pad_bit ? PH_PAD : PH_CMD;
                        end
                    end
                end
                PH_PAD: begin
                    n_pos   = pos_adv;
                    n_phase = PH_CMD;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    // ---------------- result sequencing ----------------
    always_comb begin
        ent_cnt    = {2'b00, r_ent_prim} + (r_ent_close ? 3'd3 : 3'd0);
        seq_last   = ({1'b0, r_seq} == (ent_cnt - 3'd1));
        close_step = r_seq - {1'b0, r_ent_prim};
        out_free   = !r_out_valid || !i_out_stall;
        o_in_stall = r_ent_valid && !(out_free && seq_last);
        in_acc     = i_in_valid && !o_in_stall;

        if (r_ent_prim && (r_seq == 2'd0)) begin
            cur_res = r_ent_res;
        end else begin
            cur_res             = '0;
            cur_res.kind        = KIND_SINGLE;
            cur_res.all_amps    = 1'b1;
            cur_res.script_done = 1'b1;
            cur_res.reg_addr    = (close_step == 2'd1) ? CLOSE_PAGE_REG : 8'd0;
        end
        cur_res.last = seq_last;

        n_seq       = r_seq;
        n_ent_valid = r_ent_valid;
        if (r_ent_valid && out_free) begin
            if (seq_last) begin
                n_seq       = '0;
                n_ent_valid = 1'b0;
            end else begin
                n_seq = r_seq + 2'd1;
            end
        end
        if (in_acc) begin
            n_ent_valid = p_prim || p_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_odd   <= 1'b0;
            r_phase <= PH_DONE;
            r_pos   <= '0;
            r_cmd   <= '0;
            r_rem   <= '0;
            r_first <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SCRIPT_LENGTH) begin
                    r_len <= i_cfg_data;
                end else if (i_cfg_index == CFG_START_ODD) begin
                    r_odd <= i_cfg_data[0];
                end
            end
            if (in_acc) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_cmd   <= n_cmd;
                r_rem   <= n_rem;
                r_first <= n_first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= 1'b0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ent_valid <= n_ent_valid;
            r_seq       <= n_seq;
            if (out_free) begin
                r_out_valid <= r_ent_valid;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ent_prim  <= p_prim;
            r_ent_close <= p_close;
            r_ent_res   <= p_res;
        end
        if (out_free && r_ent_valid) begin
            r_out <= cur_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    a_seq_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ent_valid |-> ({1'b0, r_seq} < ent_cnt))
        else $error("result index beyond slot count");

    a_seq_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ent_valid |-> (r_seq == 2'd0))
        else $error("result index not cleared with empty slot");

    a_close_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && p_close) |=> (r_phase == PH_DONE))
        else $error("parser not parked after closing sequence");

    a_close_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.script_done) |->
        (o_out_data.all_amps && (o_out_data.kind == KIND_SINGLE)))
        else $error("closing result malformed");

    a_stall_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_ent_valid)
        else $error("input stalled with empty slot");

endmodule
